FILE: rtl/kvrd_pkg.sv
// ----------------------------------------------------------------------------
// kvrd_pkg
// Shared types and codes for the key/value record deframer.
// ----------------------------------------------------------------------------
package kvrd_pkg;

  localparam logic [31:0] MAGIC_RESET  = 32'h4B56_3030;
  localparam logic [2:0]  HEADER_LAST  = 3'd3;
  localparam logic [2:0]  ENTRY_MIN    = 3'd5;

  localparam logic [2:0] KIND_HEADER = 3'd0;
  localparam logic [2:0] KIND_KEYLEN = 3'd1;
  localparam logic [2:0] KIND_KEY    = 3'd2;
  localparam logic [2:0] KIND_VALLEN = 3'd3;
  localparam logic [2:0] KIND_VALUE  = 3'd4;
  localparam logic [2:0] KIND_IGNORE = 3'd5;

  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_SHORT_HDR   = 3'd1;
  localparam logic [2:0] ST_BAD_VERSION = 3'd2;
  localparam logic [2:0] ST_ENTRY_SHORT = 3'd3;
  localparam logic [2:0] ST_KEY_CUT     = 3'd4;
  localparam logic [2:0] ST_VALUE_CUT   = 3'd5;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic [2:0]  byte_kind;
    logic        field_end;
    logic [15:0] field_length;
    logic        blob_done;
    logic [2:0]  status;
  } result_t;

endpackage

FILE: rtl/kvrd_parse.sv
// ----------------------------------------------------------------------------
// kvrd_parse
// Parse state and per-byte classification; state advances on each transaction.
// ----------------------------------------------------------------------------
module kvrd_parse (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              advance,
  input  logic [7:0]        data_byte,
  input  logic              last_byte,
  input  logic [31:0]       expected_magic,
  output kvrd_pkg::result_t res
);
  import kvrd_pkg::*;

  logic [2:0]  phase_r,     phase_nxt;
  logic [1:0]  hdr_pos_r,   hdr_pos_nxt;
  logic        mismatch_r,  mismatch_nxt;
  logic [15:0] left_r,      left_nxt;
  logic [7:0]  len_hi_r,    len_hi_nxt;
  logic [2:0]  ent_cnt_r,   ent_cnt_nxt;
  logic [2:0]  err_r,       err_nxt;

  logic [7:0]  want;
  logic [15:0] flen;
  logic        entry_done;
  logic [2:0]  status;

  always_comb begin
    case (hdr_pos_r)
      2'd0:    want = expected_magic[31:24];
      2'd1:    want = expected_magic[23:16];
      2'd2:    want = expected_magic[15:8];
      default: want = expected_magic[7:0];
    endcase
  end

  always_comb begin
    phase_nxt    = phase_r;
    hdr_pos_nxt  = hdr_pos_r;
    mismatch_nxt = mismatch_r;
    left_nxt     = left_r;
    len_hi_nxt   = len_hi_r;
    ent_cnt_nxt  = ent_cnt_r;
    err_nxt      = err_r;
    flen         = {len_hi_r, data_byte};
    entry_done   = 1'b0;
    status       = ST_OK;
    res          = '0;
    res.out_byte  = data_byte;
    res.byte_kind = KIND_IGNORE;
    res.blob_done = last_byte;

    unique case (phase_r) inside
      KIND_HEADER: begin
        res.byte_kind = KIND_HEADER;
        if (data_byte != want) mismatch_nxt = 1'b1;
        if ({1'b0, hdr_pos_r} == HEADER_LAST) begin
          if (mismatch_nxt) begin
            err_nxt   = ST_BAD_VERSION;
            phase_nxt = KIND_IGNORE;
          end else begin
            phase_nxt   = KIND_KEYLEN;
            left_nxt    = 16'd2;
            ent_cnt_nxt = 3'd0;
          end
          status = err_nxt;
        end else begin
          hdr_pos_nxt = hdr_pos_r + 2'd1;
          status      = ST_SHORT_HDR;
        end
      end
      KIND_KEYLEN, KIND_VALLEN, KIND_KEY, KIND_VALUE: begin
        res.byte_kind = phase_r;
        if (ent_cnt_r < ENTRY_MIN) ent_cnt_nxt = ent_cnt_r + 3'd1;
        if (phase_r == KIND_KEYLEN || phase_r == KIND_VALLEN) begin
          if (left_r != 16'd1) begin
            len_hi_nxt = data_byte;
            left_nxt   = 16'd1;
          end else begin
            res.field_length = flen;
            res.field_end    = 1'b1;
            if (phase_r == KIND_KEYLEN) begin
              if (flen == 16'd0) begin
                phase_nxt = KIND_VALLEN;
                left_nxt  = 16'd2;
              end else begin
                phase_nxt = KIND_KEY;
                left_nxt  = flen;
              end
            end else if (flen == 16'd0) begin
              entry_done = 1'b1;
            end else begin
              phase_nxt = KIND_VALUE;
              left_nxt  = flen;
            end
          end
        end else begin
          if (left_r <= 16'd1) begin
            res.field_end = 1'b1;
            if (phase_r == KIND_KEY) begin
              phase_nxt = KIND_VALLEN;
              left_nxt  = 16'd2;
            end else begin
              entry_done = 1'b1;
            end
          end else begin
            left_nxt = left_r - 16'd1;
          end
        end
        if (ent_cnt_nxt < ENTRY_MIN)
          status = ST_ENTRY_SHORT;
        else if (entry_done)
          status = ST_OK;
        else if (phase_nxt == KIND_KEYLEN || phase_nxt == KIND_KEY)
          status = ST_KEY_CUT;
        else
          status = ST_VALUE_CUT;
        if (entry_done) begin
          phase_nxt   = KIND_KEYLEN;
          left_nxt    = 16'd2;
          ent_cnt_nxt = 3'd0;
        end
      end
      default: begin
        status = err_r;
      end
    endcase

    res.status = last_byte ? status : ST_OK;

    if (last_byte) begin
      phase_nxt    = KIND_HEADER;
      hdr_pos_nxt  = 2'd0;
      mismatch_nxt = 1'b0;
      left_nxt     = 16'd0;
      len_hi_nxt   = 8'd0;
      ent_cnt_nxt  = 3'd0;
      err_nxt      = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= KIND_HEADER;
      hdr_pos_r  <= 2'd0;
      mismatch_r <= 1'b0;
      left_r     <= 16'd0;
      len_hi_r   <= 8'd0;
      ent_cnt_r  <= 3'd0;
      err_r      <= ST_OK;
    end else if (advance) begin
      phase_r    <= phase_nxt;
      hdr_pos_r  <= hdr_pos_nxt;
      mismatch_r <= mismatch_nxt;
      left_r     <= left_nxt;
      len_hi_r   <= len_hi_nxt;
      ent_cnt_r  <= ent_cnt_nxt;
      err_r      <= err_nxt;
    end
  end

endmodule

FILE: rtl/key_value_record_deframer_core.sv
// ----------------------------------------------------------------------------
// key_value_record_deframer_core
// Length-prefixed key/value blob deframer: header check, per-byte tagging.
// ----------------------------------------------------------------------------
//  channel | ports                                  | direction
//  input   | in_valid/in_ready, in_data_byte, in_last_byte | in
//  result  | out_valid/out_ready, out_byte .. out_status   | out
//  config  | cfg_wr_en, cfg_wr_data (expected magic)       | in
//
//  One byte per cycle sustained while out_ready holds; a byte passes from
//  the input register to the result register.
//  Parse state updates as a byte moves from the input to the result register.
//  A stalled result holds the pipe; input takes a byte whenever its register
//  is empty or drains in the same cycle. Synchronous active-low reset.
// ----------------------------------------------------------------------------
module key_value_record_deframer_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic [2:0]  out_byte_kind,
  output logic        out_field_end,
  output logic [15:0] out_field_length,
  output logic        out_blob_done,
  output logic [2:0]  out_status,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data
);
  import kvrd_pkg::*;

  logic        s_valid_r;
  logic [7:0]  s_byte_r;
  logic        s_last_r;
  logic        o_valid_r;
  result_t     o_res_r;
  result_t     res;
  logic [31:0] magic_r;
  logic        advance;

  assign advance  = s_valid_r && (!o_valid_r || out_ready);
  assign in_ready = !s_valid_r || advance;

  kvrd_parse u_parse (
    .clk            (clk),
    .rst_n          (rst_n),
    .advance        (advance),
    .data_byte      (s_byte_r),
    .last_byte      (s_last_r),
    .expected_magic (magic_r),
    .res            (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      magic_r <= MAGIC_RESET;
    end else if (cfg_wr_en) begin
      magic_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_valid_r <= 1'b0;
      o_valid_r <= 1'b0;
    end else begin
      if (in_ready) s_valid_r <= in_valid;
      if (advance)
        o_valid_r <= 1'b1;
      else if (out_ready)
        o_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s_byte_r <= in_data_byte;
      s_last_r <= in_last_byte;
    end
    if (advance) o_res_r <= res;
  end

  assign out_valid        = o_valid_r;
  assign out_byte         = o_res_r.out_byte;
  assign out_byte_kind    = o_res_r.byte_kind;
  assign out_field_end    = o_res_r.field_end;
  assign out_field_length = o_res_r.field_length;
  assign out_blob_done    = o_res_r.blob_done;
  assign out_status       = o_res_r.status;

endmodule

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for key_value_record_deframer_core. A short table of
// blobs walks every status and the length extremes; random blobs follow,
// mostly well formed with random truncation, plus noise and bad headers. A
// byte-level tracker predicts each tagged result; outputs are compared field
// by field under random sender gaps and receiver stalls, for several magics.
// ----------------------------------------------------------------------------
module testbench;
  import kvrd_pkg::*;

  localparam int unsigned LIMIT_CYCLES = 400000;
  localparam int unsigned PHASE_BYTES  = 220;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       typed;
    result_t    want;
  } blob_byte_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_data_byte = '0;
  logic        in_last_byte = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_byte;
  logic [2:0]  out_byte_kind;
  logic        out_field_end;
  logic [15:0] out_field_length;
  logic        out_blob_done;
  logic [2:0]  out_status;
  logic        cfg_wr_en = 1'b0;
  logic [31:0] cfg_wr_data = '0;

  // tracker state
  logic [31:0] ps_magic;
  logic [2:0]  ps_phase;
  logic [2:0]  ps_hdr_pos;
  logic        ps_mismatch;
  logic [15:0] ps_left;
  logic [7:0]  ps_len_hi;
  logic [2:0]  ps_entry_cnt;
  logic [2:0]  ps_err;

  blob_byte_t  blob_bytes_q[$];
  blob_byte_t  cur_item;
  result_t     tag_results_due[$];
  logic [7:0]  blob_buf[$];
  blob_byte_t  dir_tbl [37];

  int unsigned in_idle_pct = 0;
  int unsigned out_stall_pct = 0;
  int unsigned err_cnt = 0;
  int unsigned bytes_in = 0;
  int unsigned results_checked = 0;
  int unsigned blobs_done = 0;
  int unsigned status_seen [8];
  int unsigned cycle_cnt = 0;

  key_value_record_deframer_core u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data_byte     (in_data_byte),
    .in_last_byte     (in_last_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_byte         (out_byte),
    .out_byte_kind    (out_byte_kind),
    .out_field_end    (out_field_end),
    .out_field_length (out_field_length),
    .out_blob_done    (out_blob_done),
    .out_status       (out_status),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic void clear_parse_state();
    ps_phase     = KIND_HEADER;
    ps_hdr_pos   = '0;
    ps_mismatch  = 1'b0;
    ps_left      = '0;
    ps_len_hi    = '0;
    ps_entry_cnt = '0;
    ps_err       = ST_OK;
  endfunction

  function automatic result_t tag_byte(input logic [7:0] b, input logic last);
    result_t     r;
    int          pos;
    logic [15:0] len;
    logic        entry_done;
    r = '0;
    r.out_byte = b;
    r.blob_done = last;
    r.byte_kind = KIND_IGNORE;
    entry_done = 1'b0;
    case (ps_phase) inside
      KIND_HEADER: begin
        pos = int'(ps_hdr_pos[1:0]);
        r.byte_kind = KIND_HEADER;
        if (b != ps_magic[8*(3-pos) +: 8]) ps_mismatch = 1'b1;
        if (pos == HEADER_LAST) begin
          if (ps_mismatch) begin
            ps_err = ST_BAD_VERSION;
            ps_phase = KIND_IGNORE;
          end else begin
            ps_phase = KIND_KEYLEN;
            ps_left = 16'd2;
            ps_entry_cnt = '0;
          end
          r.status = ps_err;
        end else begin
          ps_hdr_pos = ps_hdr_pos + 3'd1;
          r.status = ST_SHORT_HDR;
        end
      end
      KIND_KEYLEN, KIND_KEY, KIND_VALLEN, KIND_VALUE: begin
        r.byte_kind = ps_phase;
        if (ps_entry_cnt < ENTRY_MIN) ps_entry_cnt = ps_entry_cnt + 3'd1;
        if (ps_phase == KIND_KEYLEN || ps_phase == KIND_VALLEN) begin
          if (ps_left != 16'd1) begin
            ps_len_hi = b;
            ps_left = 16'd1;
          end else begin
            len = {ps_len_hi, b};
            r.field_length = len;
            r.field_end = 1'b1;
            if (ps_phase == KIND_KEYLEN) begin
              if (len == 16'd0) begin
                ps_phase = KIND_VALLEN;
                ps_left = 16'd2;
              end else begin
                ps_phase = KIND_KEY;
                ps_left = len;
              end
            end else if (len == 16'd0) begin
              entry_done = 1'b1;
            end else begin
              ps_phase = KIND_VALUE;
              ps_left = len;
            end
          end
        end else if (ps_left <= 16'd1) begin
          r.field_end = 1'b1;
          if (ps_phase == KIND_KEY) begin
            ps_phase = KIND_VALLEN;
            ps_left = 16'd2;
          end else begin
            entry_done = 1'b1;
          end
        end else begin
          ps_left = ps_left - 16'd1;
        end
        if (ps_entry_cnt < ENTRY_MIN) r.status = ST_ENTRY_SHORT;
        else if (entry_done) r.status = ST_OK;
        else if (ps_phase == KIND_KEYLEN || ps_phase == KIND_KEY) r.status = ST_KEY_CUT;
        else r.status = ST_VALUE_CUT;
        if (entry_done) begin
          ps_phase = KIND_KEYLEN;
          ps_left = 16'd2;
          ps_entry_cnt = '0;
        end
      end
      default: r.status = ps_err;
    endcase
    if (last) clear_parse_state();
    else r.status = ST_OK;
    return r;
  endfunction

  function automatic void accept_byte();
    result_t pred;
    pred = tag_byte(cur_item.data, cur_item.last);
    if (cur_item.typed) pred = cur_item.want;
    tag_results_due.push_back(pred);
    bytes_in++;
    if (pred.blob_done) begin
      blobs_done++;
      status_seen[pred.status]++;
    end
  endfunction

  function automatic void check_result();
    result_t want;
    results_checked++;
    if (tag_results_due.size() == 0) begin
      $error("unexpected result transaction, out_byte %0h", out_byte);
      err_cnt++;
      return;
    end
    want = tag_results_due.pop_front();
    if (out_byte !== want.out_byte) begin
      $error("out_byte: expected %0h, got %0h", want.out_byte, out_byte);
      err_cnt++;
    end
    if (out_byte_kind !== want.byte_kind) begin
      $error("out_byte_kind: expected %0d, got %0d", want.byte_kind, out_byte_kind);
      err_cnt++;
    end
    if (out_field_end !== want.field_end) begin
      $error("out_field_end: expected %0d, got %0d", want.field_end, out_field_end);
      err_cnt++;
    end
    if (out_field_length !== want.field_length) begin
      $error("out_field_length: expected %0d, got %0d", want.field_length, out_field_length);
      err_cnt++;
    end
    if (out_blob_done !== want.blob_done) begin
      $error("out_blob_done: expected %0d, got %0d", want.blob_done, out_blob_done);
      err_cnt++;
    end
    if (out_status !== want.status) begin
      $error("out_status: expected %0d, got %0d", want.status, out_status);
      err_cnt++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      out_ready <= 1'b0;
    end else begin
      if (in_valid && in_ready) accept_byte();
      if (out_valid && out_ready) check_result();
      if (!in_valid || in_ready) begin
        if (blob_bytes_q.size() != 0 && $urandom_range(1, 100) > in_idle_pct) begin
          cur_item = blob_bytes_q.pop_front();
          in_valid <= 1'b1;
          in_data_byte <= cur_item.data;
          in_last_byte <= cur_item.last;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_ready <= ($urandom_range(1, 100) > out_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results pending", cycle_cnt,
               tag_results_due.size());
      $display("** key_value_record_deframer_core: FAILED **");
      $finish;
    end
  end

  function automatic blob_byte_t plain_row(input logic [7:0] data, input logic last);
    return '{data: data, last: last, typed: 1'b0, want: '0};
  endfunction

  function automatic blob_byte_t known_row(input logic [7:0] data, input logic last,
                                           input logic [2:0] kind, input logic fend,
                                           input logic [15:0] flen, input logic [2:0] st);
    return '{data: data, last: last, typed: 1'b1,
             want: '{out_byte: data, byte_kind: kind, field_end: fend,
                     field_length: flen, blob_done: last, status: st}};
  endfunction

  function automatic int unsigned pick_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 65) return $urandom_range(0, 4);
    if (r < 93) return $urandom_range(5, 24);
    return $urandom_range(25, 65535);
  endfunction

  // mostly well-formed blobs; long fields are cut short, ending the blob
  function automatic void build_blob();
    int unsigned sel;
    int unsigned bad_pos;
    int unsigned n_fields;
    int unsigned n_hdr;
    int unsigned nb;
    int unsigned cut;
    logic [15:0] fl;
    logic [7:0]  hb;
    bit          stop;
    blob_buf.delete();
    stop = 1'b0;
    sel = $urandom_range(0, 99);
    if (sel < 6) begin
      repeat ($urandom_range(1, 12)) blob_buf.push_back(8'($urandom));
    end else if (sel < 11) begin
      n_hdr = $urandom_range(1, 3);
      for (int i = 0; i < int'(n_hdr); i++)
        blob_buf.push_back(ps_magic[8*(3-i) +: 8]);
    end else begin
      bad_pos = (sel < 20) ? $urandom_range(0, 3) : 4;
      for (int i = 0; i < 4; i++) begin
        hb = ps_magic[8*(3-i) +: 8];
        if (i == bad_pos) hb = hb ^ 8'($urandom_range(1, 255));
        blob_buf.push_back(hb);
      end
      if (bad_pos < 4) begin
        repeat ($urandom_range(0, 6)) blob_buf.push_back(8'($urandom));
        n_fields = 0;
      end else begin
        n_fields = 2 * $urandom_range(0, 4);
      end
      for (int f = 0; f < n_fields && !stop; f++) begin
        fl = 16'(pick_len());
        blob_buf.push_back(fl[15:8]);
        blob_buf.push_back(fl[7:0]);
        nb = 32'(fl);
        if (fl > 16'd40) begin
          nb = $urandom_range(0, 6);
          stop = 1'b1;
        end
        repeat (nb) blob_buf.push_back(8'($urandom));
      end
      if (!stop && $urandom_range(0, 3) == 0) begin
        cut = (blob_buf.size() > 5) ? $urandom_range(5, blob_buf.size() - 1)
                                    : $urandom_range(1, blob_buf.size() - 1);
        while (blob_buf.size() > cut) blob_buf.delete(blob_buf.size() - 1);
      end
    end
    foreach (blob_buf[i])
      blob_bytes_q.push_back(plain_row(blob_buf[i], i == blob_buf.size() - 1));
  endfunction

  task automatic wait_drained();
    @(negedge clk);
    while (blob_bytes_q.size() != 0 || in_valid || tag_results_due.size() != 0)
      @(negedge clk);
  endtask

  initial begin
    logic [31:0] magic_list [5];
    int unsigned idle_list [5];
    int unsigned stall_list [5];
    int unsigned phase_bytes;
    int unsigned blob_n;
    magic_list = '{32'h0000_0000, 32'hFFFF_FFFF, 32'($urandom), MAGIC_RESET,
                   32'($urandom)};
    idle_list  = '{0, 67, 0, 20, 0};
    stall_list = '{0, 0, 67, 20, 0};
    ps_magic = MAGIC_RESET;
    clear_parse_state();
    dir_tbl = '{
      // short header
      known_row(8'h4B, 1'b1, KIND_HEADER, 1'b0, 16'd0, ST_SHORT_HDR),
      // bad version, then an ignored byte
      known_row(8'hFF, 1'b0, KIND_HEADER, 1'b0, 16'd0, ST_OK),
      plain_row(8'h00, 1'b0), plain_row(8'hFF, 1'b0), plain_row(8'h00, 1'b0),
      known_row(8'hAA, 1'b1, KIND_IGNORE, 1'b0, 16'd0, ST_BAD_VERSION),
      // header only
      plain_row(8'h4B, 1'b0), plain_row(8'h56, 1'b0), plain_row(8'h30, 1'b0),
      known_row(8'h30, 1'b1, KIND_HEADER, 1'b0, 16'd0, ST_OK),
      // entry short
      plain_row(8'h4B, 1'b0), plain_row(8'h56, 1'b0), plain_row(8'h30, 1'b0),
      plain_row(8'h30, 1'b0),
      known_row(8'hFF, 1'b1, KIND_KEYLEN, 1'b0, 16'd0, ST_ENTRY_SHORT),
      // zero key length, value cut
      plain_row(8'h4B, 1'b0), plain_row(8'h56, 1'b0), plain_row(8'h30, 1'b0),
      plain_row(8'h30, 1'b0),
      known_row(8'h00, 1'b0, KIND_KEYLEN, 1'b0, 16'd0, ST_OK),
      plain_row(8'h00, 1'b0), plain_row(8'h00, 1'b0),
      known_row(8'h02, 1'b0, KIND_VALLEN, 1'b1, 16'd2, ST_OK),
      known_row(8'hAA, 1'b1, KIND_VALUE, 1'b0, 16'd0, ST_VALUE_CUT),
      // empty entry, then max key length, key cut
      plain_row(8'h4B, 1'b0), plain_row(8'h56, 1'b0), plain_row(8'h30, 1'b0),
      plain_row(8'h30, 1'b0),
      plain_row(8'h00, 1'b0), plain_row(8'h00, 1'b0), plain_row(8'h00, 1'b0),
      plain_row(8'h00, 1'b0),
      known_row(8'hFF, 1'b0, KIND_KEYLEN, 1'b0, 16'd0, ST_OK),
      known_row(8'hFF, 1'b0, KIND_KEYLEN, 1'b1, 16'hFFFF, ST_OK),
      plain_row(8'h01, 1'b0), plain_row(8'h02, 1'b0),
      known_row(8'h03, 1'b1, KIND_KEY, 1'b0, 16'd0, ST_KEY_CUT)
    };

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    foreach (dir_tbl[i]) blob_bytes_q.push_back(dir_tbl[i]);
    wait_drained();

    for (int p = 0; p < 5; p++) begin
      repeat (4) @(posedge clk);
      cfg_wr_en <= 1'b1;
      cfg_wr_data <= magic_list[p];
      ps_magic = magic_list[p];
      @(posedge clk);
      cfg_wr_en <= 1'b0;
      @(negedge clk);
      in_idle_pct = idle_list[p];
      out_stall_pct = stall_list[p];
      phase_bytes = 0;
      blob_n = 0;
      while (phase_bytes < PHASE_BYTES) begin
        while (blob_bytes_q.size() > 40) @(negedge clk);
        build_blob();
        phase_bytes += blob_buf.size();
        blob_n++;
        // hold the sender until the pipe is empty
        if (p == 4 && blob_n % 4 == 0) wait_drained();
      end
      wait_drained();
    end

    in_idle_pct = 0;
    out_stall_pct = 0;
    repeat (8) @(posedge clk);
    $display("%0d bytes sent, %0d results checked over %0d blobs, five magic settings",
             bytes_in, results_checked, blobs_done);
    $display("blob status counts: ok %0d, short header %0d, bad version %0d, %s %0d, %s %0d, %s %0d",
             status_seen[ST_OK], status_seen[ST_SHORT_HDR], status_seen[ST_BAD_VERSION],
             "entry short", status_seen[ST_ENTRY_SHORT], "key cut", status_seen[ST_KEY_CUT],
             "value cut", status_seen[ST_VALUE_CUT]);
    if (err_cnt == 0 && tag_results_due.size() == 0) begin
      $display("** key_value_record_deframer_core: PASSED **");
    end else begin
      $display("** key_value_record_deframer_core: FAILED **");
    end
    $finish;
  end

endmodule
